// ----- design/otcs_pkg.sv -----
// Shared types, constants and helper functions of the one-tissue compartment simulator.
`timescale 1ns / 1ps
`default_nettype none

package otcs_pkg;

    // Number formats.
    localparam int FRAC_BITS = 16;
    localparam int VALUE_W   = 32;
    localparam int TIME_W    = 32;
    localparam int RATE_W    = 32;
    localparam int RATE_FRAC = 24;
    localparam int VB_W      = 25;
    localparam int INT_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Shared multiplier: a 33 bit operand covers the magnitude of a sum of two values.
    localparam int MUL_A_W = VALUE_W + 1;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int HALF_W  = 32;

    // Rounded trapezoid area, signed.
    localparam int TRAP_W = PROD_W - FRAC_BITS + 1;

    // Numerator accumulator and divider widths.
    localparam int ACC_W    = 116;
    localparam int DEN_W    = 65;
    localparam int DIVN_W   = ACC_W + 1;
    localparam int DIVD_W   = DEN_W + 1;
    localparam int QUOT_W   = 32;
    localparam int REM_W    = DIVD_W + QUOT_W;
    localparam int DCNT_W   = $clog2(QUOT_W);

    localparam int SHIFT_LO = FRAC_BITS + 1;
    localparam int SHIFT_HI = SHIFT_LO + HALF_W;

    localparam logic [DEN_W-1:0] DEN_BASE =
        {{(DEN_W-1){1'b0}}, 1'b1} << (RATE_FRAC + FRAC_BITS + 1);

    localparam logic [QUOT_W-1:0] LIM_POS = {1'b0, {(QUOT_W-1){1'b1}}};
    localparam logic [QUOT_W-1:0] LIM_NEG = {1'b1, {(QUOT_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_K1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VB = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BACKWARD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_ART_MUL,
        S_ART_ACC,
        S_VB_ACC,
        S_K1L_ACC,
        S_K1H_ACC,
        S_K2L_ACC,
        S_K2H_ACC,
        S_KDT,
        S_KDL_ACC,
        S_KDH_ACC,
        S_PREP,
        S_DSTART,
        S_DWAIT,
        S_TIS_MUL,
        S_TIS_ACC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    // Rounds a doubled trapezoid product to nearest (ties away from zero) and applies the sign.
    function automatic logic [TRAP_W-1:0] trap_round(input logic [PROD_W-1:0] p,
                                                     input logic neg);
        logic [PROD_W:0]          tmp;
        logic [PROD_W-FRAC_BITS-1:0] mag;
        tmp = {1'b0, p} + ({{PROD_W{1'b0}}, 1'b1} << FRAC_BITS);
        mag = tmp[PROD_W:FRAC_BITS+1];
        return neg ? (TRAP_W'(0) - {1'b0, mag}) : {1'b0, mag};
    endfunction

    // Saturating add of a trapezoid area to a running integral, limits +-(2^63-1).
    function automatic logic [INT_W-1:0] sat_add(input logic [INT_W-1:0] a,
                                                 input logic [TRAP_W-1:0] b);
        logic [INT_W:0] s;
        s = {a[INT_W-1], a} + {{(INT_W+1-TRAP_W){b[TRAP_W-1]}}, b};
        if (!s[INT_W] && s[INT_W-1]) begin
            return {1'b0, {(INT_W-1){1'b1}}};
        end else if (s[INT_W] && (!s[INT_W-1] || (s[INT_W-2:0] == '0))) begin
            return {1'b1, {(INT_W-2){1'b0}}, 1'b1};
        end else begin
            return s[INT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/otcs_mul.sv -----
// Shared registered multiplier used for every product of the tissue update.
`timescale 1ns / 1ps
`default_nettype none

module otcs_mul
    import otcs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [MUL_A_W-1:0] op_a,
    input  wire logic [MUL_B_W-1:0] op_b,
    output logic      [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb begin
        prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- design/otcs_div.sv -----
// Restoring divider that yields one quotient bit per cycle and flags quotient overflow.
`timescale 1ns / 1ps
`default_nettype none

module otcs_div
    import otcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVN_W-1:0] num,
    input  wire logic [DIVD_W-1:0] den,
    output div_stat_t              stat,
    output logic      [QUOT_W-1:0] quot
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (start) begin
            // A quotient that needs more than QUOT_W bits saturates anyway.
            ovf_next  = (num >= {{(DIVN_W-DIVD_W-QUOT_W){1'b0}}, den, {QUOT_W{1'b0}}});
            rem_next  = num[REM_W-1:0];
            dsh_next  = {1'b0, den, {(QUOT_W-1){1'b0}}};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_reg - dsh_reg) : rem_reg;
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg  <= ovf_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

// ----- design/one_tissue_compartment_sim.sv -----
// Top level of the one-tissue compartment simulator: sequencer, state and configuration.
// A sample with a positive time step builds its numerator term by term on the shared
// multiplier and then runs the shared divider's 32 quotient steps. A sample that is ignored,
// runs backward in time or repeats the previous time skips both and goes straight to its result.
// One request at a time: a new request is accepted only once the previous result is emitted.
// Reset (aresetn low, synchronous) clears the rates, the curve state and all control.
`timescale 1ns / 1ps
`default_nettype none

module one_tissue_compartment_sim
    import otcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port.
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,

    // Sample requests.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_start_of_curve,
    input  wire logic [TIME_W-1:0]     s_sample_time,
    input  wire logic signed [VALUE_W-1:0] s_arterial_activity,

    // Tissue results.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [VALUE_W-1:0]  m_tissue_activity,
    output logic [STATUS_W-1:0]        m_status
);

    // Sequencer state.
    state_t state_reg, state_next;

    // Rate registers.
    logic [RATE_W-1:0]  k1_reg, k1_next;
    logic [RATE_W-1:0]  k2_reg, k2_next;
    logic [VB_W-1:0]    vb_reg, vb_next;

    // Curve state, kept between samples.
    logic [TIME_W-1:0]  prev_time_reg, prev_time_next;
    logic [VALUE_W-1:0] prev_art_reg, prev_art_next;
    logic [INT_W-1:0]   art_int_reg, art_int_next;
    logic [VALUE_W-1:0] prev_tis_reg, prev_tis_next;
    logic [INT_W-1:0]   tis_int_reg, tis_int_next;
    logic               aborted_reg, aborted_next;

    // Working registers of the sample in flight.
    logic [TIME_W-1:0]  t_reg, t_next;
    logic [VALUE_W-1:0] ci_reg, ci_next;
    logic [TIME_W-1:0]  dt_reg, dt_next;
    logic [2*HALF_W-1:0] k2dt_reg, k2dt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [DIVN_W-1:0]  div_num_reg, div_num_next;
    logic [DIVD_W-1:0]  div_den_reg, div_den_next;
    logic [VALUE_W-1:0] ct_reg, ct_next;
    logic [VALUE_W-1:0] res_tis_reg, res_tis_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_tis_reg, m_tis_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    // Shared multiplier and divider connections.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic               div_start;
    div_stat_t          div_stat;
    logic [QUOT_W-1:0]  quot;

    // Derived values.
    logic [VALUE_W:0]   art_sum;
    logic [VALUE_W:0]   art_mag;
    logic [VALUE_W:0]   tis_sum;
    logic [VALUE_W:0]   tis_mag;
    logic [VALUE_W-1:0] ci_mag;
    logic [VALUE_W-1:0] pt_mag;
    logic [INT_W-1:0]   ai_mag;
    logic [INT_W-1:0]   ti_mag;
    logic [TIME_W-1:0]  dt_calc;
    logic               backward;
    logic               out_free;
    logic [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]   num_mag;
    logic [DEN_W-1:0]   den_val;
    logic [QUOT_W-1:0]  lim;
    logic [QUOT_W-1:0]  q_sat;

    // Magnitudes feed the unsigned multiplier; signs are applied when the product is summed.
    assign art_sum  = {ci_reg[VALUE_W-1], ci_reg} + {prev_art_reg[VALUE_W-1], prev_art_reg};
    assign art_mag  = art_sum[VALUE_W] ? ((VALUE_W+1)'(0) - art_sum) : art_sum;
    assign tis_sum  = {prev_tis_reg[VALUE_W-1], prev_tis_reg} + {ct_reg[VALUE_W-1], ct_reg};
    assign tis_mag  = tis_sum[VALUE_W] ? ((VALUE_W+1)'(0) - tis_sum) : tis_sum;
    assign ci_mag   = ci_reg[VALUE_W-1] ? (VALUE_W'(0) - ci_reg) : ci_reg;
    assign pt_mag   = prev_tis_reg[VALUE_W-1] ? (VALUE_W'(0) - prev_tis_reg) : prev_tis_reg;
    assign ai_mag   = art_int_reg[INT_W-1] ? (INT_W'(0) - art_int_reg) : art_int_reg;
    assign ti_mag   = tis_int_reg[INT_W-1] ? (INT_W'(0) - tis_int_reg) : tis_int_reg;
    assign dt_calc  = t_reg - prev_time_reg;
    assign backward = (t_reg < prev_time_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod};
    assign num_mag  = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
    assign den_val  = DEN_BASE + {1'b0, k2dt_reg};
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign q_sat    = (div_stat.ovf || (quot > lim)) ? lim : quot;

    otcs_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    otcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .stat    (div_stat),
        .quot    (quot)
    );

    // Next state. The numerator is built term by term from the multiplier, one product
    // per state, and then the divider runs its quotient steps.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (aborted_reg || backward || (dt_calc == '0)) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_ART_MUL;
                end
            end
            S_ART_MUL: state_next = S_ART_ACC;
            S_ART_ACC: state_next = S_VB_ACC;
            S_VB_ACC:  state_next = S_K1L_ACC;
            S_K1L_ACC: state_next = S_K1H_ACC;
            S_K1H_ACC: state_next = S_K2L_ACC;
            S_K2L_ACC: state_next = S_K2H_ACC;
            S_K2H_ACC: state_next = S_KDT;
            S_KDT:     state_next = S_KDL_ACC;
            S_KDL_ACC: state_next = S_KDH_ACC;
            S_KDH_ACC: state_next = S_PREP;
            S_PREP:    state_next = S_DSTART;
            S_DSTART:  state_next = S_DWAIT;
            S_DWAIT: begin
                if (div_stat.done) begin
                    state_next = S_TIS_MUL;
                end
            end
            S_TIS_MUL: state_next = S_TIS_ACC;
            S_TIS_ACC: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and operand selection for the shared units.
    // Each state that issues a product has it consumed by the state that follows.
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_ART_MUL: begin
                mul_a = art_mag;
                mul_b = dt_reg;
            end
            S_ART_ACC: begin
                mul_a = {{(MUL_A_W-VB_W){1'b0}}, vb_reg};
                mul_b = ci_mag;
            end
            S_VB_ACC: begin
                mul_a = {1'b0, ai_mag[HALF_W-1:0]};
                mul_b = k1_reg;
            end
            S_K1L_ACC: begin
                mul_a = {1'b0, ai_mag[INT_W-1:HALF_W]};
                mul_b = k1_reg;
            end
            S_K1H_ACC: begin
                mul_a = {1'b0, ti_mag[HALF_W-1:0]};
                mul_b = k2_reg;
            end
            S_K2L_ACC: begin
                mul_a = {1'b0, ti_mag[INT_W-1:HALF_W]};
                mul_b = k2_reg;
            end
            S_K2H_ACC: begin
                mul_a = {1'b0, k2_reg};
                mul_b = dt_reg;
            end
            S_KDT: begin
                // The low half of k2*dt goes straight from the product register.
                mul_a = {1'b0, prod[HALF_W-1:0]};
                mul_b = pt_mag;
            end
            S_KDL_ACC: begin
                mul_a = {1'b0, k2dt_reg[2*HALF_W-1:HALF_W]};
                mul_b = pt_mag;
            end
            S_DSTART: div_start = 1'b1;
            S_TIS_MUL: begin
                mul_a = tis_mag;
                mul_b = dt_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath and state updates.
    always_comb begin
        k1_next         = k1_reg;
        k2_next         = k2_reg;
        vb_next         = vb_reg;
        prev_time_next  = prev_time_reg;
        prev_art_next   = prev_art_reg;
        art_int_next    = art_int_reg;
        prev_tis_next   = prev_tis_reg;
        tis_int_next    = tis_int_reg;
        aborted_next    = aborted_reg;
        t_next          = t_reg;
        ci_next         = ci_reg;
        dt_next         = dt_reg;
        k2dt_next       = k2dt_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        div_num_next    = div_num_reg;
        div_den_next    = div_den_reg;
        ct_next         = ct_reg;
        res_tis_next    = res_tis_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_tis_next      = m_tis_reg;
        m_status_next   = m_status_reg;

        if (cfg_wen) begin
            case (cfg_index)
                CFG_K1:  k1_next = cfg_data[RATE_W-1:0];
                CFG_K2:  k2_next = cfg_data[RATE_W-1:0];
                CFG_VB:  vb_next = cfg_data[VB_W-1:0];
                default: k1_next = k1_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    t_next  = s_sample_time;
                    ci_next = s_arterial_activity;
                    // A new curve starts from a clean state.
                    if (s_start_of_curve) begin
                        prev_time_next = '0;
                        prev_art_next  = '0;
                        art_int_next   = '0;
                        prev_tis_next  = '0;
                        tis_int_next   = '0;
                        aborted_next   = 1'b0;
                    end
                end
            end
            S_CHECK: begin
                if (aborted_reg) begin
                    res_tis_next    = '0;
                    res_status_next = STATUS_IGNORED;
                end else if (backward) begin
                    aborted_next    = 1'b1;
                    res_tis_next    = '0;
                    res_status_next = STATUS_BACKWARD;
                end else if (dt_calc == '0) begin
                    // No time has passed: repeat the last tissue value.
                    prev_art_next   = ci_reg;
                    res_tis_next    = prev_tis_reg;
                    res_status_next = STATUS_OK;
                end else begin
                    dt_next = dt_calc;
                end
            end
            S_ART_ACC: begin
                art_int_next = sat_add(art_int_reg, trap_round(prod, art_sum[VALUE_W]));
            end
            S_VB_ACC: begin
                acc_next = ci_reg[VALUE_W-1] ? (ACC_W'(0) - (prod_ext << SHIFT_LO))
                                             : (prod_ext << SHIFT_LO);
            end
            S_K1L_ACC: begin
                acc_next = art_int_reg[INT_W-1] ? (acc_reg - (prod_ext << SHIFT_LO))
                                                : (acc_reg + (prod_ext << SHIFT_LO));
            end
            S_K1H_ACC: begin
                acc_next = art_int_reg[INT_W-1] ? (acc_reg - (prod_ext << SHIFT_HI))
                                                : (acc_reg + (prod_ext << SHIFT_HI));
            end
            S_K2L_ACC: begin
                acc_next = tis_int_reg[INT_W-1] ? (acc_reg + (prod_ext << SHIFT_LO))
                                                : (acc_reg - (prod_ext << SHIFT_LO));
            end
            S_K2H_ACC: begin
                acc_next = tis_int_reg[INT_W-1] ? (acc_reg + (prod_ext << SHIFT_HI))
                                                : (acc_reg - (prod_ext << SHIFT_HI));
            end
            S_KDT: begin
                k2dt_next = prod[2*HALF_W-1:0];
            end
            S_KDL_ACC: begin
                acc_next = prev_tis_reg[VALUE_W-1] ? (acc_reg + prod_ext)
                                                   : (acc_reg - prod_ext);
            end
            S_KDH_ACC: begin
                acc_next = prev_tis_reg[VALUE_W-1] ? (acc_reg + (prod_ext << HALF_W))
                                                   : (acc_reg - (prod_ext << HALF_W));
            end
            S_PREP: begin
                // Rounded division: (2*num + den) / (2*den).
                neg_next     = acc_reg[ACC_W-1];
                div_num_next = {num_mag, 1'b0} + {{(DIVN_W-DEN_W){1'b0}}, den_val};
                div_den_next = {den_val, 1'b0};
            end
            S_DWAIT: begin
                if (div_stat.done) begin
                    ct_next = neg_reg ? (VALUE_W'(0) - q_sat) : q_sat;
                end
            end
            S_TIS_ACC: begin
                tis_int_next    = sat_add(tis_int_reg, trap_round(prod, tis_sum[VALUE_W]));
                prev_tis_next   = ct_reg;
                prev_time_next  = t_reg;
                prev_art_next   = ci_reg;
                res_tis_next    = ct_reg;
                res_status_next = STATUS_OK;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_tis_next    = res_tis_reg;
                    m_status_next = res_status_reg;
                end
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase

        // Every result that is not a backward step or ignored records its sample time; this covers the zero-step case.
        if (state_reg == S_CHECK && !aborted_reg && !backward && dt_calc == '0) begin
            prev_time_next = t_reg;
        end
    end

    // Control, rates and curve state are cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            vb_reg        <= '0;
            prev_time_reg <= '0;
            prev_art_reg  <= '0;
            art_int_reg   <= '0;
            prev_tis_reg  <= '0;
            tis_int_reg   <= '0;
            aborted_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            k1_reg        <= k1_next;
            k2_reg        <= k2_next;
            vb_reg        <= vb_next;
            prev_time_reg <= prev_time_next;
            prev_art_reg  <= prev_art_next;
            art_int_reg   <= art_int_next;
            prev_tis_reg  <= prev_tis_next;
            tis_int_reg   <= tis_int_next;
            aborted_reg   <= aborted_next;
        end
    end

    // Working and payload registers carry no reset.
    always_ff @(posedge aclk) begin
        t_reg          <= t_next;
        ci_reg         <= ci_next;
        dt_reg         <= dt_next;
        k2dt_reg       <= k2dt_next;
        acc_reg        <= acc_next;
        neg_reg        <= neg_next;
        div_num_reg    <= div_num_next;
        div_den_reg    <= div_den_next;
        ct_reg         <= ct_next;
        res_tis_reg    <= res_tis_next;
        res_status_reg <= res_status_next;
        m_tis_reg      <= m_tis_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_tissue_activity = m_tis_reg;
    assign m_status          = m_status_reg;

endmodule

`default_nettype wire
